[rtl/core/lse_pkg.sv]
// Shared types and constants for the LED strip effect generator.
// Depends on nothing; imported by every module of the block.
package lse_pkg;

	// strip size and field widths
	localparam int MAX_LEDS = 64;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int CH_W     = 8;
	localparam int WORD_W   = 16;
	localparam int REG_W    = 32;
	localparam int RIDX_W   = 3;

	// shared divider operand widths
	localparam int NUM_W    = 15;
	localparam int DEN_W    = 7;

	// configuration register indexes
	localparam logic [RIDX_W-1:0] REG_MODE        = 3'd0;
	localparam logic [RIDX_W-1:0] REG_PARAM_COUNT = 3'd1;
	localparam logic [RIDX_W-1:0] REG_PAIR_A      = 3'd2;
	localparam logic [RIDX_W-1:0] REG_PAIR_B      = 3'd3;
	localparam logic [RIDX_W-1:0] REG_PAIR_C      = 3'd4;
	localparam logic [RIDX_W-1:0] REG_BRIGHTNESS  = 3'd5;
	localparam logic [RIDX_W-1:0] REG_LED_COUNT   = 3'd6;

	// effect mode codes
	localparam logic [2:0] MODE_OFF      = 3'd0;
	localparam logic [2:0] MODE_STATIC   = 3'd1;
	localparam logic [2:0] MODE_RAINBOW  = 3'd2;
	localparam logic [2:0] MODE_BREATHE  = 3'd3;
	localparam logic [2:0] MODE_CHASE    = 3'd4;
	localparam logic [2:0] MODE_GRADIENT = 3'd5;

	// parameter word count that turns static into segment
	localparam logic [2:0] SEGMENT_PARAMS = 3'd5;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic frame_start;
		logic led_load;
		logic c1_en;
		logic c2_en;
		logic sc_en;
		logic led_next;
		logic adv_load;
		logic adv_apply;
		logic mod_step;
		logic commit;
	} lse_cmd_t;

	// status from the datapath to the sequencer
	typedef struct packed {
		logic cnt_zero;
		logic div_busy;
		logic led_last;
		logic adv_lt;
	} lse_stat_t;

endpackage

[rtl/core/lse_div.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on lse_pkg for operand widths.
module lse_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lse_pkg::NUM_W-1:0] num,
	input  logic [lse_pkg::DEN_W-1:0] den,
	output logic                      busy,
	output logic [lse_pkg::NUM_W-1:0] quo
);
	import lse_pkg::*;

	localparam int STEP_W = $clog2(NUM_W);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  quo_q;
	logic [DEN_W:0]    rs;
	logic [DEN_W:0]    rdiff;
	logic              ge;

	// trial subtract of the shifted remainder
	assign rs    = {rem_q, quo_q[NUM_W-1]};
	assign rdiff = rs - {1'b0, den_q};
	assign ge    = (rs >= {1'b0, den_q});

	// count the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + STEP_W'(1);
			if (step_q == STEP_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// shift the dividend through, one bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], ge};
			rem_q <= ge ? rdiff[DEN_W-1:0] : rs[DEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

endmodule

[rtl/core/lse_dp.sv]
// Datapath: configuration registers, animation state, per-LED colour stages.
// Depends on lse_pkg and lse_div.
module lse_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lse_pkg::RIDX_W-1:0] cfg_index,
	input  logic [lse_pkg::REG_W-1:0]  cfg_wdata,
	input  lse_pkg::lse_cmd_t          cmd,
	output lse_pkg::lse_stat_t         stat,
	output logic [lse_pkg::IDX_W-1:0]  led_index,
	output logic [lse_pkg::CH_W-1:0]   green,
	output logic [lse_pkg::CH_W-1:0]   red,
	output logic [lse_pkg::CH_W-1:0]   blue,
	output logic                       last
);
	import lse_pkg::*;

	typedef enum logic [2:0] {
		EFF_OFF, EFF_STATIC, EFF_SEGMENT, EFF_RAINBOW, EFF_BREATHE, EFF_CHASE, EFF_GRADIENT
	} eff_t;

	localparam logic [9:0] HUE_FULL = 10'd360;

	// integer hexcone at full saturation and value
	function automatic logic [23:0] hexcone(input logic [8:0] h);
		logic [2:0]  region;
		logic [8:0]  base;
		logic [5:0]  x;
		logic [9:0]  x17;
		logic [7:0]  rem;
		logic [7:0]  inv;
		logic [15:0] qm;
		logic [15:0] tm;
		logic [7:0]  q;
		logic [7:0]  t;
		logic [23:0] rgb;
		if (h >= 9'd300) begin
			region = 3'd5; base = 9'd300;
		end else if (h >= 9'd240) begin
			region = 3'd4; base = 9'd240;
		end else if (h >= 9'd180) begin
			region = 3'd3; base = 9'd180;
		end else if (h >= 9'd120) begin
			region = 3'd2; base = 9'd120;
		end else if (h >= 9'd60) begin
			region = 3'd1; base = 9'd60;
		end else begin
			region = 3'd0; base = 9'd0;
		end
		x   = 6'(h - base);
		x17 = 10'({x, 4'b0000}) + 10'(x);
		rem = x17[9:2];
		inv = 8'd255 - rem;
		qm  = {inv, 8'd0} - 16'(inv);
		tm  = {rem, 8'd0} - 16'(rem);
		q   = qm[15:8];
		t   = tm[15:8];
		case (region)
			3'd0:    rgb = {8'hFF, t, 8'h00};
			3'd1:    rgb = {q, 8'hFF, 8'h00};
			3'd2:    rgb = {8'h00, 8'hFF, t};
			3'd3:    rgb = {8'h00, q, 8'hFF};
			3'd4:    rgb = {t, 8'h00, 8'hFF};
			default: rgb = {8'hFF, 8'h00, q};
		endcase
		return rgb;
	endfunction

	// finish c1 + d/255 with the quotient truncated toward zero
	function automatic logic [7:0] lerp_fin(input logic [7:0] c1, input logic signed [17:0] p);
		logic        neg;
		logic [16:0] mag;
		logic [16:0] sum;
		logic [7:0]  qd;
		neg = p[17];
		mag = neg ? 17'(-p) : 17'(p);
		sum = mag + 17'(mag[16:8]) + 17'd1;
		qd  = sum[15:8];
		return neg ? (c1 - qd) : (c1 + qd);
	endfunction

	function automatic logic [3:0] clamp_speed(input logic [7:0] s);
		logic [3:0] v;
		if (s == 8'd0) begin
			v = 4'd1;
		end else if (s > 8'd10) begin
			v = 4'd10;
		end else begin
			v = s[3:0];
		end
		return v;
	endfunction

	function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] b);
		logic [15:0] p;
		p = 16'(c) * 16'(b);
		return p[15:8];
	endfunction

	logic [2:0]        mode_q;
	logic [2:0]        pcnt_q;
	logic [REG_W-1:0]  pa_q;
	logic [REG_W-1:0]  pb_q;
	logic [REG_W-1:0]  pc_q;
	logic [CH_W-1:0]   bright_q;
	logic [CNT_W-1:0]  lcnt_q;
	logic              cfg_hit;

	logic [8:0]        hue_off_q;
	logic [7:0]        phase_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  adv_q;

	logic [WORD_W-1:0] w [6];
	logic [CNT_W-1:0]  cnt;
	logic [CNT_W-1:0]  cnt_m1;
	eff_t              eff;

	logic [IDX_W-1:0]  seg_start;
	logic [IDX_W-1:0]  seg_end_c;
	logic [IDX_W-1:0]  seg_end;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  end_q;

	logic [6:0]        rb_speed;
	logic [3:0]        br_speed;
	logic [3:0]        ch_speed;
	logic [4:0]        tail;
	logic [7:0]        br_factor;
	logic              grad_t0;

	logic [7:0]        dist_sum;
	logic [7:0]        dist_w;
	logic [IDX_W-1:0]  behind;
	logic              chase_on;
	logic              chase_on_q;
	logic [4:0]        tail_k;

	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic              div_busy;
	logic [NUM_W-1:0]  div_quo;

	logic [9:0]        hue_sum;
	logic [8:0]        hue_next;
	logic [7:0]        fac8;
	logic signed [8:0] opa [3];
	logic signed [17:0] prod_c [3];
	logic [8:0]        hue_s1;
	logic signed [17:0] prod_s1 [3];

	logic [23:0]       hx;
	logic [7:0]        raw_c [3];
	logic [7:0]        raw_s2 [3];

	logic [13:0]       rb_sq_q;
	logic [25:0]       step_prod;
	logic [7:0]        step8;
	logic [7:0]        step;
	logic [9:0]        hue_adv_sum;
	logic [8:0]        hue_adv;

	logic [IDX_W-1:0]  led_index_q;
	logic [CH_W-1:0]   green_q;
	logic [CH_W-1:0]   red_q;
	logic [CH_W-1:0]   blue_q;
	logic              last_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_OFF;
			pcnt_q   <= '0;
			pa_q     <= '0;
			pb_q     <= '0;
			pc_q     <= '0;
			bright_q <= 8'd128;
			lcnt_q   <= 7'd60;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:        mode_q   <= cfg_wdata[2:0];
				REG_PARAM_COUNT: pcnt_q   <= cfg_wdata[2:0];
				REG_PAIR_A:      pa_q     <= cfg_wdata;
				REG_PAIR_B:      pb_q     <= cfg_wdata;
				REG_PAIR_C:      pc_q     <= cfg_wdata;
				REG_BRIGHTNESS:  bright_q <= cfg_wdata[CH_W-1:0];
				REG_LED_COUNT:   lcnt_q   <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_hit = cfg_we && (cfg_index <= REG_LED_COUNT);

	// parameter words and derived settings
	assign w[0] = pa_q[15:0];
	assign w[1] = pa_q[31:16];
	assign w[2] = pb_q[15:0];
	assign w[3] = pb_q[31:16];
	assign w[4] = pc_q[15:0];
	assign w[5] = pc_q[31:16];

	assign cnt    = (lcnt_q > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : lcnt_q;
	assign cnt_m1 = cnt - CNT_W'(1);

	always_comb begin
		case (mode_q)
			MODE_STATIC: begin
				if ((w[0] != '0 || w[1] != '0) && pcnt_q == SEGMENT_PARAMS) begin
					eff = EFF_SEGMENT;
				end else begin
					eff = EFF_STATIC;
				end
			end
			MODE_RAINBOW:  eff = EFF_RAINBOW;
			MODE_BREATHE:  eff = EFF_BREATHE;
			MODE_CHASE:    eff = EFF_CHASE;
			MODE_GRADIENT: eff = EFF_GRADIENT;
			default:       eff = EFF_OFF;
		endcase
	end

	// clamp the segment bounds
	assign seg_start = (w[0] >= WORD_W'(cnt)) ? '0 : w[0][IDX_W-1:0];
	assign seg_end_c = (w[1] >= WORD_W'(cnt)) ? cnt_m1[IDX_W-1:0] : w[1][IDX_W-1:0];
	assign seg_end   = (seg_end_c < seg_start) ? seg_start : seg_end_c;

	assign rb_speed = (w[0] == '0) ? 7'd1 : (w[0] > 16'd100) ? 7'd100 : w[0][6:0];
	assign br_speed = clamp_speed(w[3][7:0]);
	assign ch_speed = clamp_speed(w[4][7:0]);
	assign tail     = (w[3] == '0) ? 5'd5 : (w[3] > 16'd30) ? 5'd30 : w[3][4:0];
	assign br_factor = {(phase_q[7] ? ~phase_q[6:0] : phase_q[6:0]), 1'b0};
	assign grad_t0  = (cnt == CNT_W'(1));

	// walk the LED index
	always_ff @(posedge clk) begin
		if (cmd.frame_start) begin
			idx_q <= (eff == EFF_SEGMENT) ? seg_start : '0;
			end_q <= (eff == EFF_SEGMENT) ? seg_end : cnt_m1[IDX_W-1:0];
		end else if (cmd.led_next) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// chase distance behind the head
	assign dist_sum = 8'(idx_q) + 8'(cnt) - 8'(head_q);
	assign dist_w   = (dist_sum >= 8'(cnt)) ? (dist_sum - 8'(cnt)) : dist_sum;
	assign behind   = dist_w[IDX_W-1:0];
	assign chase_on = (behind < IDX_W'(tail));
	assign tail_k   = tail - behind[4:0];

	// pick divider operands
	always_comb begin
		div_num = '0;
		div_den = DEN_W'(1);
		case (eff)
			EFF_RAINBOW: begin
				div_num = NUM_W'(idx_q) * NUM_W'(360);
				div_den = cnt;
			end
			EFF_GRADIENT: begin
				div_num = NUM_W'(idx_q) * NUM_W'(255);
				div_den = cnt_m1;
			end
			EFF_CHASE: begin
				div_num = NUM_W'({tail_k, 8'd0}) - NUM_W'(tail_k);
				div_den = DEN_W'(tail);
			end
			default: ;
		endcase
	end

	lse_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.led_load),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.led_load) begin
			chase_on_q <= chase_on;
		end
	end

	// stage 1: hue and channel products
	assign hue_sum  = 10'(div_quo[8:0]) + 10'(hue_off_q);
	assign hue_next = (hue_sum >= HUE_FULL) ? 9'(hue_sum - HUE_FULL) : hue_sum[8:0];

	always_comb begin
		case (eff)
			EFF_GRADIENT: fac8 = grad_t0 ? 8'd0 : div_quo[7:0];
			EFF_BREATHE:  fac8 = br_factor;
			EFF_CHASE:    fac8 = chase_on_q ? div_quo[7:0] : 8'd0;
			default:      fac8 = 8'd0;
		endcase
		for (int ch = 0; ch < 3; ch++) begin
			if (eff == EFF_GRADIENT) begin
				opa[ch] = $signed({1'b0, w[ch+3][7:0]}) - $signed({1'b0, w[ch][7:0]});
			end else begin
				opa[ch] = $signed({1'b0, w[ch][7:0]});
			end
			prod_c[ch] = opa[ch] * $signed({1'b0, fac8});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.c1_en) begin
			hue_s1 <= hue_next;
			for (int ch = 0; ch < 3; ch++) begin
				prod_s1[ch] <= prod_c[ch];
			end
		end
	end

	// stage 2: raw channel bytes
	always_comb begin
		hx = hexcone(hue_s1);
		for (int ch = 0; ch < 3; ch++) begin
			case (eff)
				EFF_STATIC:   raw_c[ch] = w[ch][7:0];
				EFF_SEGMENT:  raw_c[ch] = w[ch+2][7:0];
				EFF_RAINBOW:  raw_c[ch] = hx[8*(2-ch) +: 8];
				EFF_BREATHE:  raw_c[ch] = prod_s1[ch][15:8];
				EFF_CHASE:    raw_c[ch] = prod_s1[ch][15:8];
				EFF_GRADIENT: raw_c[ch] = lerp_fin(w[ch][7:0], prod_s1[ch]);
				default:      raw_c[ch] = 8'd0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.c2_en) begin
			for (int ch = 0; ch < 3; ch++) begin
				raw_s2[ch] <= raw_c[ch];
			end
		end
	end

	// stage 3: brightness into the output register
	always_ff @(posedge clk) begin
		if (cmd.sc_en) begin
			led_index_q <= idx_q;
			red_q       <= scale8(raw_s2[0], bright_q);
			green_q     <= scale8(raw_s2[1], bright_q);
			blue_q      <= scale8(raw_s2[2], bright_q);
			last_q      <= (idx_q == end_q);
		end
	end

	// square the rainbow speed ahead of the step
	always_ff @(posedge clk) begin
		if (cmd.adv_load) begin
			rb_sq_q <= 14'(rb_speed) * 14'(rb_speed);
		end
	end

	// rainbow step: speed squared over fifty by reciprocal multiply, plus one, capped
	assign step_prod   = 26'(rb_sq_q) * 26'(13'd5243);
	assign step8       = step_prod[25:18] + 8'd1;
	assign step        = (step8 > 8'd60) ? 8'd60 : step8;
	assign hue_adv_sum = 10'(hue_off_q) + 10'(step);
	assign hue_adv     = (hue_adv_sum >= HUE_FULL) ? 9'(hue_adv_sum - HUE_FULL)
	                                               : hue_adv_sum[8:0];

	// advance the animation after the frame; a write to any configuration register clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_off_q <= '0;
			phase_q   <= '0;
			head_q    <= '0;
			adv_q     <= '0;
		end else if (cfg_hit) begin
			hue_off_q <= '0;
			phase_q   <= '0;
			head_q    <= '0;
			adv_q     <= '0;
		end else begin
			if (cmd.adv_apply) begin
				case (eff)
					EFF_RAINBOW: begin
						hue_off_q <= hue_adv;
						adv_q     <= '0;
					end
					EFF_BREATHE: begin
						phase_q <= phase_q + 8'(br_speed);
						adv_q   <= '0;
					end
					EFF_CHASE:   adv_q <= CNT_W'(head_q) + CNT_W'(ch_speed);
					default:     adv_q <= '0;
				endcase
			end
			if (cmd.mod_step) begin
				adv_q <= adv_q - cnt;
			end
			if (cmd.commit && eff == EFF_CHASE) begin
				head_q <= adv_q[IDX_W-1:0];
			end
		end
	end

	assign stat.cnt_zero = (cnt == '0);
	assign stat.div_busy = div_busy;
	assign stat.led_last = (idx_q == end_q);
	assign stat.adv_lt   = (adv_q < cnt);

	assign led_index = led_index_q;
	assign green     = green_q;
	assign red       = red_q;
	assign blue      = blue_q;
	assign last      = last_q;

endmodule

[rtl/core/lse_ctrl.sv]
// Sequencer: steps each LED through divide, colour and output beats.
// Depends on lse_pkg for the command and status structs.
module lse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               frame_request,
	output logic               out_valid,
	input  logic               out_ready,
	input  lse_pkg::lse_stat_t stat,
	output lse_pkg::lse_cmd_t  cmd
);
	import lse_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_LOAD, ST_DIV, ST_C1, ST_C2, ST_SC, ST_OUT,
		ST_ADV_LOAD, ST_ADV_APPLY, ST_ADV_MOD
	} state_t;

	state_t state_q;
	logic   take;
	logic   go;

	assign take = in_valid && (state_q == ST_IDLE);
	assign go   = take && frame_request && !stat.cnt_zero;

	// hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (go) state_q <= ST_LOAD;
				end
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (!stat.div_busy) state_q <= ST_C1;
				end
				ST_C1: state_q <= ST_C2;
				ST_C2: state_q <= ST_SC;
				ST_SC: state_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready) state_q <= stat.led_last ? ST_ADV_LOAD : ST_LOAD;
				end
				ST_ADV_LOAD: state_q <= ST_ADV_APPLY;
				ST_ADV_APPLY: state_q <= ST_ADV_MOD;
				ST_ADV_MOD: begin
					if (stat.adv_lt) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// decode commands
	always_comb begin
		cmd             = '0;
		cmd.frame_start = go;
		cmd.led_load    = (state_q == ST_LOAD);
		cmd.c1_en       = (state_q == ST_C1);
		cmd.c2_en       = (state_q == ST_C2);
		cmd.sc_en       = (state_q == ST_SC);
		cmd.led_next    = (state_q == ST_OUT) && out_ready && !stat.led_last;
		cmd.adv_load    = (state_q == ST_ADV_LOAD);
		cmd.adv_apply   = (state_q == ST_ADV_APPLY);
		cmd.mod_step    = (state_q == ST_ADV_MOD) && !stat.adv_lt;
		cmd.commit      = (state_q == ST_ADV_MOD) && stat.adv_lt;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

endmodule

[rtl/core/led_strip_effect_generator.sv]
// LED strip effect generator: one accepted frame request yields one beat per LED in
// index order (all LEDs, or the clamped range in segment mode), each carrying the index,
// the brightness-scaled green, red and blue bytes, and last on the final LED. An empty
// request, or a zero LED count, yields no beat. Each LED passes through a load step,
// the shared bit-serial divider (15 quotient steps, then the state that sees it finish;
// hue position, gradient fraction or chase tail factor), two colour stages, the
// brightness stage and the output beat, which waits for out_ready. After the last LED
// the animation state advances: the rainbow speed is squared, the step is applied, then
// a subtract loop runs for the chase head. A new request is taken only once the
// previous frame is done.
// Depends on lse_pkg, lse_ctrl, lse_dp and lse_div.
module led_strip_effect_generator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       frame_request,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lse_pkg::IDX_W-1:0]  led_index,
	output logic [lse_pkg::CH_W-1:0]   green,
	output logic [lse_pkg::CH_W-1:0]   red,
	output logic [lse_pkg::CH_W-1:0]   blue,
	output logic                       last,
	input  logic                       cfg_we,
	input  logic [lse_pkg::RIDX_W-1:0] cfg_index,
	input  logic [lse_pkg::REG_W-1:0]  cfg_wdata
);
	import lse_pkg::*;

	lse_cmd_t  cmd;
	lse_stat_t stat;

	lse_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.frame_request (frame_request),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.stat          (stat),
		.cmd           (cmd)
	);

	lse_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.stat      (stat),
		.led_index (led_index),
		.green     (green),
		.red       (red),
		.blue      (blue),
		.last      (last)
	);

	// one frame at a time: no request is taken while a beat is offered
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while a beat is offered");

	// an empty request produces nothing and leaves the block ready
	a_empty_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !frame_request) |=> (in_ready && !out_valid))
		else $error("empty request started a frame");

	// the frame continues after a beat that is not the last
	a_frame_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> !in_ready)
		else $error("frame ended before its last beat");

endmodule
